// ===== sv/cnlc_pkg.sv =====
// Shared types and constants for the card number Luhn classifier.
package cnlc_pkg;

    localparam int NUM_BITS        = 64;
    localparam int NUM_DIGITS      = 20;
    localparam int DIGIT_W         = 4;
    localparam int BCD_W           = NUM_DIGITS * DIGIT_W;
    localparam int BITS_PER_STEP   = 8;
    localparam int CONV_STEPS      = NUM_BITS / BITS_PER_STEP;
    localparam int DIGITS_PER_STEP = 2;
    localparam int SCAN_STEPS      = NUM_DIGITS / DIGITS_PER_STEP;
    localparam int STEP_W          = $clog2(SCAN_STEPS);
    localparam int COUNT_W         = 5;
    localparam int LEAD_W          = 7;
    localparam int SUM_W           = 4;

    localparam logic [COUNT_W-1:0] MAX_DIGITS = COUNT_W'(19);

    localparam logic [LEAD_W-1:0] PFX_A_LO  = LEAD_W'(40);
    localparam logic [LEAD_W-1:0] PFX_A_HI  = LEAD_W'(49);
    localparam logic [LEAD_W-1:0] PFX_B_ONE = LEAD_W'(34);
    localparam logic [LEAD_W-1:0] PFX_B_TWO = LEAD_W'(37);
    localparam logic [LEAD_W-1:0] PFX_C_LO  = LEAD_W'(51);
    localparam logic [LEAD_W-1:0] PFX_C_HI  = LEAD_W'(55);

    localparam logic [COUNT_W-1:0] LEN_A_SHORT = COUNT_W'(13);
    localparam logic [COUNT_W-1:0] LEN_A_LONG  = COUNT_W'(16);
    localparam logic [COUNT_W-1:0] LEN_B       = COUNT_W'(15);
    localparam logic [COUNT_W-1:0] LEN_C       = COUNT_W'(16);

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_ISSUER1 = 2'd1,
        KIND_ISSUER2 = 2'd2,
        KIND_ISSUER3 = 2'd3
    } kind_t;

    typedef struct packed {
        logic load;
        logic conv;
        logic scan;
        logic store;
    } cmd_t;

endpackage

// ===== sv/cnlc_ctrl.sv =====
// Sequencing state machine for the card number Luhn classifier.
module cnlc_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output cnlc_pkg::cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t                      state_reg, state_next;
    logic [cnlc_pkg::STEP_W-1:0] step_reg, step_next;
    logic                        m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                cmd.conv  = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == cnlc_pkg::STEP_W'(cnlc_pkg::CONV_STEPS - 1)) begin
                    step_next  = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan  = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == cnlc_pkg::STEP_W'(cnlc_pkg::SCAN_STEPS - 1)) begin
                    step_next  = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.store  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.store) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// ===== sv/cnlc_dp.sv =====
// Datapath: binary to decimal conversion, digit scan, Luhn sum and classification.
module cnlc_dp (
    input  logic                          aclk,
    input  cnlc_pkg::cmd_t                cmd,
    input  logic [cnlc_pkg::NUM_BITS-1:0] s_card_number,
    output logic [1:0]                    m_card_kind,
    output logic                          m_luhn_ok,
    output logic [cnlc_pkg::COUNT_W-1:0]  m_digit_count,
    output logic [cnlc_pkg::LEAD_W-1:0]   m_leading_pair
);

    logic [cnlc_pkg::NUM_BITS-1:0] bin_reg, bin_next;
    logic [cnlc_pkg::BCD_W-1:0]    bcd_reg, bcd_next;
    logic [cnlc_pkg::COUNT_W-1:0]  pos_reg, pos_next;
    logic [cnlc_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic [cnlc_pkg::LEAD_W-1:0]   lead_reg, lead_next;
    logic [cnlc_pkg::DIGIT_W-1:0]  prev_reg, prev_next;
    logic [cnlc_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic [1:0]                    kind_reg;
    logic                          ok_reg;
    logic [cnlc_pkg::COUNT_W-1:0]  count_out_reg;
    logic [cnlc_pkg::LEAD_W-1:0]   lead_out_reg;

    logic [cnlc_pkg::BCD_W-1:0]    conv_bcd;
    logic [cnlc_pkg::NUM_BITS-1:0] conv_bin;
    logic [cnlc_pkg::DIGIT_W-1:0]  dig_lo, dig_hi;
    logic [cnlc_pkg::DIGIT_W:0]    dbl_hi, acc_a, acc_b;
    logic [cnlc_pkg::DIGIT_W-1:0]  add_hi;
    logic [cnlc_pkg::LEAD_W-1:0]   lead_hi, lead_lo;
    logic                          luhn_ok;
    cnlc_pkg::kind_t               kind;

    function automatic logic [cnlc_pkg::LEAD_W-1:0] LEAD_W_EXT(
        input logic [cnlc_pkg::DIGIT_W-1:0] d
    );
        return {{(cnlc_pkg::LEAD_W - cnlc_pkg::DIGIT_W){1'b0}}, d};
    endfunction

    // Shift-and-add-3 conversion, several bits per cycle.
    always_comb begin
        logic [cnlc_pkg::BCD_W-1:0]    b;
        logic [cnlc_pkg::NUM_BITS-1:0] n;
        b = bcd_reg;
        n = bin_reg;
        for (int k = 0; k < cnlc_pkg::BITS_PER_STEP; k++) begin
            for (int j = 0; j < cnlc_pkg::NUM_DIGITS; j++) begin
                if (b[j*cnlc_pkg::DIGIT_W +: cnlc_pkg::DIGIT_W] >= 4'd5) begin
                    b[j*cnlc_pkg::DIGIT_W +: cnlc_pkg::DIGIT_W] =
                        b[j*cnlc_pkg::DIGIT_W +: cnlc_pkg::DIGIT_W] + 4'd3;
                end
            end
            b = {b[cnlc_pkg::BCD_W-2:0], n[cnlc_pkg::NUM_BITS-1]};
            n = {n[cnlc_pkg::NUM_BITS-2:0], 1'b0};
        end
        conv_bcd = b;
        conv_bin = n;
    end

    // Two digits per scan step: even position plain, odd position doubled.
    always_comb begin
        dig_lo = bcd_reg[cnlc_pkg::DIGIT_W-1:0];
        dig_hi = bcd_reg[2*cnlc_pkg::DIGIT_W-1:cnlc_pkg::DIGIT_W];
        dbl_hi = {dig_hi, 1'b0};
        add_hi = (dbl_hi > 5'd9) ? cnlc_pkg::DIGIT_W'(dbl_hi - 5'd9)
                                 : cnlc_pkg::DIGIT_W'(dbl_hi);
        acc_a  = {1'b0, sum_reg} + {1'b0, dig_lo};
        if (acc_a >= 5'd10) begin
            acc_a = acc_a - 5'd10;
        end
        acc_b  = acc_a + {1'b0, add_hi};
        if (acc_b >= 5'd10) begin
            acc_b = acc_b - 5'd10;
        end
        lead_hi = (LEAD_W_EXT(dig_hi) << 3) + (LEAD_W_EXT(dig_hi) << 1) + LEAD_W_EXT(dig_lo);
        lead_lo = (pos_reg == '0) ? LEAD_W_EXT(dig_lo)
                : (LEAD_W_EXT(dig_lo) << 3) + (LEAD_W_EXT(dig_lo) << 1)
                  + LEAD_W_EXT(prev_reg);
    end

    always_comb begin
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        lead_next  = lead_reg;
        prev_next  = prev_reg;
        sum_next   = sum_reg;
        if (cmd.load) begin
            bin_next   = s_card_number;
            bcd_next   = '0;
            pos_next   = '0;
            count_next = '0;
            lead_next  = '0;
            prev_next  = '0;
            sum_next   = '0;
        end else if (cmd.conv) begin
            bin_next = conv_bin;
            bcd_next = conv_bcd;
        end else if (cmd.scan) begin
            bcd_next  = bcd_reg >> (cnlc_pkg::DIGITS_PER_STEP * cnlc_pkg::DIGIT_W);
            pos_next  = pos_reg + cnlc_pkg::COUNT_W'(cnlc_pkg::DIGITS_PER_STEP);
            prev_next = dig_hi;
            sum_next  = cnlc_pkg::SUM_W'(acc_b);
            if (dig_hi != '0) begin
                count_next = pos_reg + cnlc_pkg::COUNT_W'(2);
                lead_next  = lead_hi;
            end else if (dig_lo != '0) begin
                count_next = pos_reg + cnlc_pkg::COUNT_W'(1);
                lead_next  = lead_lo;
            end
        end
    end

    always_comb begin
        luhn_ok = (sum_reg == '0);
        kind    = cnlc_pkg::KIND_NONE;
        if (luhn_ok && count_reg <= cnlc_pkg::MAX_DIGITS) begin
            if (lead_reg >= cnlc_pkg::PFX_A_LO && lead_reg <= cnlc_pkg::PFX_A_HI) begin
                if (count_reg == cnlc_pkg::LEN_A_SHORT || count_reg == cnlc_pkg::LEN_A_LONG) begin
                    kind = cnlc_pkg::KIND_ISSUER1;
                end
            end else if (lead_reg == cnlc_pkg::PFX_B_ONE || lead_reg == cnlc_pkg::PFX_B_TWO) begin
                if (count_reg == cnlc_pkg::LEN_B) begin
                    kind = cnlc_pkg::KIND_ISSUER2;
                end
            end else if (lead_reg >= cnlc_pkg::PFX_C_LO && lead_reg <= cnlc_pkg::PFX_C_HI) begin
                if (count_reg == cnlc_pkg::LEN_C) begin
                    kind = cnlc_pkg::KIND_ISSUER3;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg   <= bin_next;
        bcd_reg   <= bcd_next;
        pos_reg   <= pos_next;
        count_reg <= count_next;
        lead_reg  <= lead_next;
        prev_reg  <= prev_next;
        sum_reg   <= sum_next;
        if (cmd.store) begin
            kind_reg      <= kind;
            ok_reg        <= luhn_ok;
            count_out_reg <= count_reg;
            lead_out_reg  <= lead_reg;
        end
    end

    assign m_card_kind    = kind_reg;
    assign m_luhn_ok      = ok_reg;
    assign m_digit_count  = count_out_reg;
    assign m_leading_pair = lead_out_reg;

endmodule

// ===== sv/card_number_luhn_classifier_unit.sv =====
// Top level of the card number Luhn classifier.
//
//  channel   handshake           payload
//  s_        s_valid / s_ready   s_card_number[63:0]
//  m_        m_valid / m_ready   m_card_kind, m_luhn_ok, m_digit_count, m_leading_pair
//
// From accept to result, a number passes through an accept, 8 conversion
// steps of 8 bits each, 10 scan steps of two digits each, and a store.
// The next number is accepted the cycle after the store, while the result waits.
// aresetn is synchronous, active low, and clears the controller and m_valid.
// A stalled m_ready holds the finished number in its last step until the
// output register frees up.
module card_number_luhn_classifier_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [cnlc_pkg::NUM_BITS-1:0] s_card_number,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_card_kind,
    output logic                          m_luhn_ok,
    output logic [cnlc_pkg::COUNT_W-1:0]  m_digit_count,
    output logic [cnlc_pkg::LEAD_W-1:0]   m_leading_pair
);

    cnlc_pkg::cmd_t cmd;

    cnlc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    cnlc_dp u_dp (
        .aclk           (aclk),
        .cmd            (cmd),
        .s_card_number  (s_card_number),
        .m_card_kind    (m_card_kind),
        .m_luhn_ok      (m_luhn_ok),
        .m_digit_count  (m_digit_count),
        .m_leading_pair (m_leading_pair)
    );

endmodule
